// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the meter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define GFRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GFRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/gfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Gated frame meter package
// Shared widths, reset values, level thresholds and transfer types.
// ----------------------------------------------------------------------------
package gfrm_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned SQ_BITS     = 47;  // square of a full-scale sample is 2^46
  localparam int unsigned SUM_BITS    = 59;  // 4096 squares of at most 2^46
  localparam int unsigned NUM_BITS    = 60;  // left plus right sum
  localparam int unsigned DEN_BITS    = 32;
  localparam int unsigned LVL_S_BITS  = 48;

  localparam logic [12:0] MAX_FRAME   = 13'd4096;

  // Configuration register indexes.
  localparam logic [2:0] REG_STEREO  = 3'd0;
  localparam logic [2:0] REG_FLEN    = 3'd1;
  localparam logic [2:0] REG_GLOW    = 3'd2;
  localparam logic [2:0] REG_GHIGH   = 3'd3;
  localparam logic [2:0] REG_DEFLVL  = 3'd4;

  // Register reset values.
  localparam logic        RST_STEREO = 1'b1;
  localparam logic [12:0] RST_FLEN   = 13'd2400;
  localparam logic [6:0]  RST_GLOW   = 7'd15;
  localparam logic [6:0]  RST_GHIGH  = 7'd40;
  localparam logic [6:0]  RST_DEFLVL = 7'd31;

  // 1e-10 in Q46 and the per-dB thresholds of one decade in Q46.
  localparam logic [47:0] EPS_Q46 = 48'd7037;
  localparam logic [47:0] LVL_THRESH [10] = '{
    48'd62716209263637, 48'd49817255792983, 48'd39571252852849, 48'd31432563424433,
    48'd24967772617788, 48'd19832606748484, 48'd15753599508504, 48'd12513528888144,
    48'd9939849311893,  48'd7895502957338
  };

  // One closed frame as handed from the front to the back.
  typedef struct packed {
    logic [NUM_BITS-1:0] num;   // square sum to divide
    logic [13:0]         den;   // pairs, doubled in stereo
    logic                last;  // frame closes the stream
  } frame_t;

  // Request into the shared divider.
  typedef struct packed {
    logic                start;
    logic [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
  } div_req_t;

  // Status of the shared divider.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [NUM_BITS-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/gfrm_front.sv =====
// ----------------------------------------------------------------------------
// Meter front end
// Squares each sample pair, sums the squares per frame and queues closed frames.
// ----------------------------------------------------------------------------
module gfrm_front import gfrm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   stereo_i,
  input  logic [12:0]            frame_length_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] left_i,
  input  logic [SAMPLE_BITS-1:0] right_i,
  input  logic                   last_i,
  output logic                   push_o,
  output frame_t                 push_data_o,
  input  logic                   full_i
);

  logic [12:0]         pairs_q, pairs_d, pairs_inc, len_eff;
  logic                close;
  logic                s1_valid_q, s1_close_q, s1_last_q;
  logic [12:0]         s1_n_q;
  logic [SQ_BITS-1:0]  sq_l_q, sq_r_q;
  logic [2*SAMPLE_BITS-1:0] prod_l, prod_r;
  logic [SUM_BITS-1:0] lsum_q, rsum_q, nl, nr;
  logic                s1_adv, accept;

  // Effective frame length: zero acts as one, long values are capped.
  always_comb begin
    if (frame_length_i == 13'd0) begin
      len_eff = 13'd1;
    end else if (frame_length_i > MAX_FRAME) begin
      len_eff = MAX_FRAME;
    end else begin
      len_eff = frame_length_i;
    end
  end

  assign s1_adv     = s1_valid_q && !(s1_close_q && full_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign pairs_inc = pairs_q + 13'd1;
  assign close     = (pairs_inc >= len_eff) || last_i;
  assign pairs_d   = close ? 13'd0 : pairs_inc;
  assign prod_l    = $signed(left_i) * $signed(left_i);
  assign prod_r    = $signed(right_i) * $signed(right_i);

  // Pair count and the squaring stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q    <= 13'd0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pairs_q <= pairs_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_l_q     <= prod_l[SQ_BITS-1:0];
      sq_r_q     <= prod_r[SQ_BITS-1:0];
      s1_close_q <= close;
      s1_last_q  <= last_i;
      s1_n_q     <= pairs_inc;
    end
  end

  // Accumulation stage.
  assign nl = lsum_q + SUM_BITS'(sq_l_q);
  assign nr = rsum_q + SUM_BITS'(sq_r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsum_q <= '0;
      rsum_q <= '0;
    end else if (s1_adv) begin
      lsum_q <= s1_close_q ? '0 : nl;
      rsum_q <= s1_close_q ? '0 : nr;
    end
  end

  // A closed frame goes into the queue with its divisor.
  assign push_o = s1_adv && s1_close_q;
  always_comb begin
    push_data_o.last = s1_last_q;
    if (stereo_i) begin
      push_data_o.num = {1'b0, nl} + {1'b0, nr};
      push_data_o.den = {s1_n_q, 1'b0};
    end else begin
      push_data_o.num = {1'b0, nl};
      push_data_o.den = {1'b0, s1_n_q};
    end
  end

endmodule

// ===== rtl/gfrm_fifo.sv =====
// ----------------------------------------------------------------------------
// Frame queue
// Two-entry queue of closed frames between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gfrm_fifo import gfrm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output frame_t pop_data_o,
  output logic   empty_o
);

  frame_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  `GFRM_ASSERT(a_fifo_no_overflow, push_i |-> (!full_o || pop_i), "frame queue overflow")
  `GFRM_ASSERT(a_fifo_no_underflow, pop_i |-> !empty_o, "frame queue underflow")
  `GFRM_ASSERT(a_fifo_cnt_range, cnt_q != 2'd3, "frame queue count out of range")

endmodule

// ===== rtl/gfrm_div.sv =====
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gfrm_div import gfrm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [5:0] DIV_STEPS = 6'(NUM_BITS);

  logic [5:0]          cnt_q;
  logic                done_q;
  logic [DEN_BITS-1:0] rem_q, den_q;
  logic [NUM_BITS-1:0] quo_q;
  logic [DEN_BITS:0]   shifted, trial;

  assign shifted = {rem_q, quo_q[NUM_BITS-1]};
  assign trial   = shifted - {1'b0, den_q};

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 6'd1);
      if (req_i.start && cnt_q == 6'd0) begin
        cnt_q <= DIV_STEPS;
      end else if (cnt_q != 6'd0) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // Shift and subtract datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start && cnt_q == 6'd0) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (cnt_q != 6'd0) begin
      if (!trial[DEN_BITS]) begin
        rem_q <= trial[DEN_BITS-1:0];
        quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DEN_BITS-1:0];
        quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = cnt_q != 6'd0;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ===== rtl/gfrm_back.sv =====
// ----------------------------------------------------------------------------
// Meter back end
// Turns each queued frame into a level, gates it and keeps the running average.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gfrm_back import gfrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [6:0] gate_low_i,
  input  logic [6:0] gate_high_i,
  input  logic [6:0] default_level_i,
  input  logic       empty_i,
  input  frame_t     frame_i,
  output logic       pop_o,
  output div_req_t   div_req_o,
  input  div_rsp_t   div_rsp_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_level_o,
  output logic       out_counted_o,
  output logic [6:0] out_dialnorm_o,
  output logic       out_final_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVQ = 3'd1;
  localparam logic [2:0] ST_LVL  = 3'd2;
  localparam logic [2:0] ST_GATE = 3'd3;
  localparam logic [2:0] ST_DIVA = 3'd4;

  logic [2:0]            st_q, st_d;
  logic                  last_q;
  logic [LVL_S_BITS-1:0] s_q;
  logic [3:0]            d_q, jf;
  logic                  hit;
  logic [6:0]            level_q, level_calc;
  logic [31:0]           total_q, frames_q, total_new, frames_new;
  logic [32:0]           total_sum;
  logic                  counted, counted_q;
  logic                  out_free;
  logic [6:0]            avg;

  assign out_free = !out_valid_o || out_ready_i;
  assign pop_o    = (st_q == ST_IDLE) && !empty_i && out_free;

  // First threshold of the current decade that the scaled mean square exceeds.
  always_comb begin
    hit = 1'b0;
    jf  = 4'd0;
    for (int j = 0; j < 10; j++) begin
      if (!hit && !(d_q == 4'd0 && j == 0) && s_q > LVL_THRESH[j]) begin
        hit = 1'b1;
        jf  = 4'(j);
      end
    end
  end
  assign level_calc = hit ? ({3'b0, d_q} * 7'd10 + {3'b0, jf} - 7'd1) : 7'd99;

  // Gate and saturating running totals.
  assign counted    = (level_q > gate_low_i) && (level_q < gate_high_i);
  assign total_sum  = {1'b0, total_q} + 33'(level_q);
  assign total_new  = !counted ? total_q : (total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0]);
  assign frames_new = (counted && frames_q != 32'hFFFF_FFFF) ? frames_q + 32'd1 : frames_q;
  assign avg        = (div_rsp_i.quot[31:0] > 32'(default_level_i)) ? default_level_i
                                                                    : div_rsp_i.quot[6:0];

  // Divider requests: the frame mean square, then the final average.
  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = frame_i.num;
    div_req_o.den   = 32'(frame_i.den);
    if (pop_o) begin
      div_req_o.start = 1'b1;
    end else if (st_q == ST_GATE && last_q) begin
      div_req_o.start = 1'b1;
      div_req_o.num   = NUM_BITS'(total_new);
      div_req_o.den   = frames_new;
    end
  end

  // Sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (pop_o) st_d = ST_DIVQ;
      ST_DIVQ: if (div_rsp_i.done) st_d = ST_LVL;
      ST_LVL:  if (hit || d_q == 4'd9) st_d = ST_GATE;
      ST_GATE: st_d = last_q ? ST_DIVA : ST_IDLE;
      ST_DIVA: if (div_rsp_i.done) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      total_q     <= 32'(RST_DEFLVL);
      frames_q    <= 32'd1;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (st_q == ST_GATE) begin
        total_q  <= total_new;
        frames_q <= frames_new;
        if (!last_q) begin
          out_valid_o <= 1'b1;
        end
      end
      if (st_q == ST_DIVA && div_rsp_i.done) begin
        total_q     <= 32'(default_level_i);
        frames_q    <= 32'd1;
        out_valid_o <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      last_q <= frame_i.last;
    end
    if (st_q == ST_DIVQ && div_rsp_i.done) begin
      s_q <= div_rsp_i.quot[LVL_S_BITS-1:0] + EPS_Q46;
      d_q <= 4'd0;
    end
    if (st_q == ST_LVL) begin
      s_q <= (s_q << 3) + (s_q << 1);
      d_q <= d_q + 4'd1;
      if (hit || d_q == 4'd9) begin
        level_q <= level_calc;
      end
    end
    if (st_q == ST_GATE) begin
      counted_q      <= counted;
      out_level_o    <= level_q;
      out_counted_o  <= counted;
      out_dialnorm_o <= 7'd0;
      out_final_o    <= 1'b0;
    end
    if (st_q == ST_DIVA && div_rsp_i.done) begin
      out_level_o    <= level_q;
      out_counted_o  <= counted_q;
      out_dialnorm_o <= avg;
      out_final_o    <= 1'b1;
    end
  end

  `GFRM_ASSERT(a_div_start_idle, div_req_o.start |-> !div_rsp_i.busy,
               "divider started while busy")
  `GFRM_ASSERT(a_out_not_lost, (out_valid_o && !out_ready_i) |=> out_valid_o,
               "pending result dropped")
  `GFRM_ASSERT(a_frames_nonzero, st_q == ST_GATE |-> frames_q != 32'd0,
               "frame count reached zero")

endmodule

// ===== rtl/gated_frame_rms_dialnorm_meter_core.sv =====
// ----------------------------------------------------------------------------
// Gated frame RMS dialnorm meter
// Measures per-frame level in dB below full scale and a gated average.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  s_axis   in         one sample pair; tlast marks the end of the stream
//  m_axis   out        one frame result; tlast marks the final dialnorm
//  cfg      in         one register write, index and data
//
//  The front takes one sample pair per cycle, unless the queue is full, through a
//  two-stage square and sum. Each closed frame costs the back one divider pass, one to
//  ten level steps and a gate step; the stream end adds a divider pass for the average.
//  A two-frame queue parts the two; the input stalls only when the queue is full.
//  Reset is asynchronous and active low; no clearing pass follows it.
// ----------------------------------------------------------------------------
module gated_frame_rms_dialnorm_meter_core import gfrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample_left[23:0], sample_right[47:24]
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // frame_level[6:0], frame_counted[7], dialnorm[14:8]
  output logic        m_axis_tlast,   // is_final
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic        stereo_q;
  logic [12:0] flen_q;
  logic [6:0]  glow_q, ghigh_q, deflvl_q;
  logic        push, full, pop, empty;
  frame_t      push_data, pop_data;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [6:0]  level, dialnorm;
  logic        counted;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q <= RST_STEREO;
      flen_q   <= RST_FLEN;
      glow_q   <= RST_GLOW;
      ghigh_q  <= RST_GHIGH;
      deflvl_q <= RST_DEFLVL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEREO: stereo_q <= cfg_data_i[0];
        REG_FLEN:   flen_q   <= cfg_data_i;
        REG_GLOW:   glow_q   <= cfg_data_i[6:0];
        REG_GHIGH:  ghigh_q  <= cfg_data_i[6:0];
        REG_DEFLVL: deflvl_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  gfrm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stereo_i       (stereo_q),
    .frame_length_i (flen_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .left_i         (s_axis_tdata[23:0]),
    .right_i        (s_axis_tdata[47:24]),
    .last_i         (s_axis_tlast),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  gfrm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  gfrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gfrm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gate_low_i      (glow_q),
    .gate_high_i     (ghigh_q),
    .default_level_i (deflvl_q),
    .empty_i         (empty),
    .frame_i         (pop_data),
    .pop_o           (pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_level_o     (level),
    .out_counted_o   (counted),
    .out_dialnorm_o  (dialnorm),
    .out_final_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, dialnorm, counted, level};

endmodule

// ===== sim/tb_gated_frame_rms_dialnorm_meter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the gated frame RMS dialnorm meter
// Streams sample pairs through several register settings and compares every
// frame result against a cycle-free model of levels, gating and dialnorm.
// ----------------------------------------------------------------------------
module tb_gated_frame_rms_dialnorm_meter_core;
  import gfrm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [6:0] level;
    logic       counted;
    logic [6:0] dialnorm;
    logic       is_final;
  } frame_result_t;

  // Meter model with its own copy of the registers and the running sums.
  class meter_scoreboard;
    logic        stereo;
    logic [12:0] flen;
    logic [6:0]  glow, ghigh, deflvl;
    logic [63:0] left_sum, right_sum;
    logic [31:0] pair_count, lvl_total, frame_count;
    frame_result_t result_q[$];
    int unsigned errors;

    function new();
      stereo = RST_STEREO;
      flen = RST_FLEN;
      glow = RST_GLOW;
      ghigh = RST_GHIGH;
      deflvl = RST_DEFLVL;
      left_sum = '0;
      right_sum = '0;
      pair_count = '0;
      lvl_total = 32'(RST_DEFLVL);
      frame_count = 32'd1;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        REG_STEREO: stereo = val[0];
        REG_FLEN:   flen = val;
        REG_GLOW:   glow = val[6:0];
        REG_GHIGH:  ghigh = val[6:0];
        REG_DEFLVL: deflvl = val[6:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] square_of(logic [23:0] x);
      logic [63:0] mag;
      mag = x[23] ? ({40'b0, ~x} + 64'd1) : {40'b0, x};
      return mag * mag;
    endfunction

    function logic [63:0] add_sat60(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > 64'h0FFF_FFFF_FFFF_FFFF) ? 64'h0FFF_FFFF_FFFF_FFFF : s;
    endfunction

    // Walk the decades: each step of one dB compares against one threshold.
    function logic [6:0] db_level(logic [63:0] q);
      logic [63:0] s;
      int unsigned lvl;
      s = q + 64'(EPS_Q46);
      lvl = 0;
      for (int d = 0; d < 10; d++) begin
        for (int j = 0; j < 10; j++) begin
          if (d == 0 && j == 0) continue;
          if (s > 64'(LVL_THRESH[j])) return 7'(lvl);
          lvl = d * 10 + j;
        end
        s = s * 10;
      end
      return 7'(lvl);
    endfunction

    function void note_pair(logic [23:0] l, logic [23:0] r, logic last);
      logic [31:0] len, avg;
      logic [63:0] q;
      frame_result_t res;
      len = (flen == 0) ? 32'd1 : (flen > MAX_FRAME) ? 32'(MAX_FRAME) : 32'(flen);
      left_sum = add_sat60(left_sum, square_of(l));
      right_sum = add_sat60(right_sum, square_of(r));
      if (pair_count != 32'hFFFF_FFFF) pair_count++;
      if (pair_count < len && !last) return;
      if (stereo) q = (left_sum + right_sum) / (64'(pair_count) * 2);
      else q = left_sum / 64'(pair_count);
      res.level = db_level(q);
      res.counted = (res.level > glow) && (res.level < ghigh);
      if (res.counted) begin
        lvl_total = (lvl_total > 32'hFFFF_FFFF - 32'(res.level)) ?
                    32'hFFFF_FFFF : lvl_total + 32'(res.level);
        if (frame_count != 32'hFFFF_FFFF) frame_count++;
      end
      left_sum = '0;
      right_sum = '0;
      pair_count = '0;
      res.dialnorm = '0;
      res.is_final = last;
      if (last) begin
        avg = lvl_total / frame_count;
        if (avg > 32'(deflvl)) avg = 32'(deflvl);
        res.dialnorm = avg[6:0];
        lvl_total = 32'(deflvl);
        frame_count = 32'd1;
      end
      result_q.push_back(res);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t exp_res;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_res = result_q.pop_front();
      if (got !== exp_res) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp level %0d counted %0d dialnorm %0d final %0d, got %0d %0d %0d %0d",
                   exp_res.level, exp_res.counted, exp_res.dialnorm, exp_res.is_final,
                   got.level, got.counted, got.dialnorm, got.is_final);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  meter_scoreboard sb = new();
  bit quiet_tx = 0;
  bit quiet_rx = 0;
  bit hold_rx = 0;
  int unsigned cycles = 0;

  gated_frame_rms_dialnorm_meter_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tlast(s_last),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tlast(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_gated_frame_rms_dialnorm_meter_core NOT OK");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // One sample pair transaction, followed by the model update.
  task automatic send_pair(logic [23:0] l, logic [23:0] r, logic last);
    int unsigned gap;
    gap = draw_gap(quiet_tx);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {r, l};
    s_last <= last;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_pair(l, r, last);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all expected results, then let the back end finish any frame work.
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (sb.result_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic st, logic [12:0] fl, logic [6:0] gl, logic [6:0] gh,
                          logic [6:0] dl);
    write_reg(REG_STEREO, {12'b0, st});
    write_reg(REG_FLEN, fl);
    write_reg(REG_GLOW, {6'b0, gl});
    write_reg(REG_GHIGH, {6'b0, gh});
    write_reg(REG_DEFLVL, {6'b0, dl});
  endtask

  // Samples spread over the whole dynamic range, with the extremes mixed in.
  function automatic logic [23:0] rand_sample();
    logic signed [23:0] raw;
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: begin
        raw = 24'($urandom);
        return raw >>> $urandom_range(0, 23);
      end
    endcase
  endfunction

  task automatic random_pairs(int n);
    for (int i = 0; i < n; i++)
      send_pair(rand_sample(), rand_sample(), $urandom_range(0, 24) == 0);
  endtask

  // Result side: random stalls, and one long hold-off when asked.
  initial begin
    int unsigned gap;
    int unsigned held;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(quiet_rx);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (hold_rx) begin
        m_ready <= 1'b0;
        held = 0;
        while (held < 2500) begin
          @(posedge clk);
          held++;
        end
        hold_rx = 0;
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
      sb.check_result({m_data[6:0], m_data[7], m_data[14:8], m_last});
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full scale, minimum and silence, one frame per pair.
    set_regs(1'b1, 13'd1, 7'd0, 7'd100, 7'd100);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_pair(24'h800000, 24'h800000, 1'b0);
    send_pair(24'h000000, 24'h000000, 1'b0);
    send_pair(24'h7FFFFF, 24'h000000, 1'b0);
    send_pair(24'h000001, 24'hFFFFFF, 1'b1);
    settle();
    // Mono, and a zero frame length that acts as one.
    set_regs(1'b0, 13'd0, 7'd100, 7'd0, 7'd0);
    send_pair(24'h800000, 24'h123456, 1'b0);
    send_pair(24'h000400, 24'h7FFFFF, 1'b1);
    settle();
    // Oversized frame length, closed short by the end of the stream.
    write_reg(REG_FLEN, 13'h1FFF);
    send_pair(24'h400000, 24'h400000, 1'b0);
    send_pair(24'hC00000, 24'h400000, 1'b0);
    send_pair(24'h001000, 24'h400000, 1'b1);
    settle();
    // Frame length lowered below the pairs already held.
    set_regs(1'b1, 13'd64, 7'd15, 7'd40, 7'd31);
    for (int i = 0; i < 6; i++) send_pair(24'h010000, 24'hFF0000, 1'b0);
    settle();
    write_reg(REG_FLEN, 13'd4);
    send_pair(24'h010000, 24'h000000, 1'b0);
    // Mode changed in the middle of a frame, and writes to unused register indexes.
    for (int i = 0; i < 2; i++) send_pair(24'h020000, 24'h7FFFFF, 1'b0);
    settle();
    write_reg(REG_STEREO, 13'd0);
    write_reg(3'd5, 13'h1ABC);
    write_reg(3'd7, 13'h0001);
    send_pair(24'h020000, 24'h7FFFFF, 1'b0);
    send_pair(24'h020000, 24'h7FFFFF, 1'b1);
    settle();

    // Random phases over a range of settings.
    set_regs(1'b1, 13'd1, 7'd15, 7'd40, 7'd31);
    random_pairs(120);
    settle();
    set_regs(1'b0, 13'd3, 7'd10, 7'd60, 7'd50);
    random_pairs(100);
    settle();
    set_regs(1'b1, 13'd64, 7'd0, 7'd100, 7'd100);
    random_pairs(130);
    settle();
    set_regs(1'b0, 13'd2, 7'd0, 7'd0, 7'd0);
    random_pairs(80);
    settle();
    set_regs(1'b1, 13'd5, 7'd100, 7'd100, 7'd100);
    random_pairs(60);
    settle();
    // Long hold on the result side while pairs keep coming.
    set_regs(1'b1, 13'd1, 7'd20, 7'd30, 7'd25);
    quiet_tx = 1;
    hold_rx = 1;
    random_pairs(150);
    settle();
    // No idling on either side, one long frame closed short.
    set_regs(1'b0, 13'd4096, 7'd15, 7'd40, 7'd31);
    quiet_rx = 1;
    for (int i = 0; i < 60; i++) send_pair(rand_sample(), rand_sample(), i == 59);
    settle();
    quiet_tx = 0;
    quiet_rx = 0;
    set_regs(1'b1, 13'd7, 7'd5, 7'd90, 7'd60);
    random_pairs(150);
    settle();
    set_regs(1'b0, 13'd1, 7'd40, 7'd15, 7'd31);
    random_pairs(80);
    settle();

    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("tb_gated_frame_rms_dialnorm_meter_core OK");
    end else begin
      $display("tb_gated_frame_rms_dialnorm_meter_core NOT OK");
    end
    $finish;
  end

endmodule
